// ===== rtl/cstrip_pkg.sv =====
`default_nettype none

package cstrip_pkg;

    // Line geometry
    localparam int unsigned LINE_LEN    = 64;
    localparam int unsigned STORE_DEPTH = 64;
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
    localparam int unsigned CNT_W       = ADDR_W + 1;
    localparam int unsigned CHAR_W      = 8;

    // Characters of interest
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

    typedef enum logic [2:0] {
        LM_CODE  = 3'd0,
        LM_SLASH = 3'd1,
        LM_STAR  = 3'd2,
        LM_BLOCK = 3'd3,
        LM_BSTAR = 3'd4,
        LM_LINE  = 3'd5
    } t_lex_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_EMIT
    } t_state;

    // Outcome of one byte through the lexer: new mode and up to two kept bytes
    typedef struct packed {
        t_lex_mode         mode;
        logic [1:0]        cnt;
        logic [CHAR_W-1:0] b0;
        logic [CHAR_W-1:0] b1;
    } t_lex_res;

    function automatic logic is_content(logic [CHAR_W-1:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_LBRACE, CH_RBRACE});
    endfunction

    // Mode that a byte leaves behind when it arrives in plain code
    function automatic t_lex_mode code_mode(logic [CHAR_W-1:0] c);
        t_lex_mode m;
        if (c == CH_SLASH) begin
            m = LM_SLASH;
        end else if (c == CH_STAR) begin
            m = LM_STAR;
        end else begin
            m = LM_CODE;
        end
        return m;
    endfunction

    function automatic logic code_keeps(logic [CHAR_W-1:0] c);
        return (c != CH_SLASH) && (c != CH_STAR);
    endfunction

    function automatic t_lex_res lex_step(t_lex_mode m, logic [CHAR_W-1:0] c);
        t_lex_res r;
        r.mode = m;
        r.cnt  = 2'd0;
        r.b0   = c;
        r.b1   = c;
        case (m)
            LM_SLASH: begin
                if (c == CH_STAR) begin
                    r.mode = LM_BLOCK;
                end else if (c == CH_SLASH) begin
                    r.mode = LM_LINE;
                end else begin
                    r.b0   = CH_SLASH;
                    r.cnt  = code_keeps(c) ? 2'd2 : 2'd1;
                    r.mode = code_mode(c);
                end
            end
            LM_STAR: begin
                if (c == CH_SLASH) begin
                    r.mode = LM_CODE;
                end else if (c == CH_STAR) begin
                    r.b0  = CH_STAR;
                    r.cnt = 2'd1;
                end else begin
                    r.b0   = CH_STAR;
                    r.cnt  = code_keeps(c) ? 2'd2 : 2'd1;
                    r.mode = code_mode(c);
                end
            end
            LM_BLOCK: begin
                if (c == CH_STAR) begin
                    r.mode = LM_BSTAR;
                end else if (c == CH_NL) begin
                    r.cnt = 2'd1;
                end
            end
            LM_BSTAR: begin
                if (c == CH_SLASH) begin
                    r.mode = LM_CODE;
                end else if (c != CH_STAR) begin
                    r.mode = LM_BLOCK;
                    if (c == CH_NL) begin
                        r.cnt = 2'd1;
                    end
                end
            end
            LM_LINE: begin
                if (c == CH_NL) begin
                    r.cnt  = 2'd1;
                    r.mode = LM_CODE;
                end
            end
            default: begin
                r.mode = code_mode(c);
                r.cnt  = code_keeps(c) ? 2'd1 : 2'd0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cstrip_if.sv =====
`default_nettype none

// Raw byte channel
interface cstrip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

// Stripped line byte channel
interface cstrip_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last;

    modport source (output valid, output char_out, output last, input ready);
    modport sink   (input valid, input char_out, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/cstrip_ram.sv =====
`default_nettype none

module cstrip_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, hold when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/c_comment_stripper.sv =====
`default_nettype none

// C comment stripper with blank-line collapse. Raw source bytes come in on
// i_in, one per beat; block and line comments and stray star-slash pairs are
// removed, and each finished line (ended by a newline, by end_of_input, or
// after 64 raw bytes) leaves on o_out byte by byte with last on its final
// byte, unless it and the line ended before it are both blank (no letter,
// no brace). A beat with end_of_input set and a NUL byte only flushes. Each
// input beat is accepted and run through the lexer in ST_IDLE; its kept
// byte, if any, is then written into the line store in ST_WRITE, with a second
// write when a held-back slash or star is kept along with the following
// byte; the single write port of the 64 x 8 line store sets this. An emitted
// line then streams from the store at one byte per cycle while the receiver
// is ready, via its registered read port; the next input beat is taken once
// its last read is issued, while the output path still holds its final bytes.
module c_comment_stripper (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cstrip_in_if.sink   i_in,
    cstrip_out_if.source o_out
);

    import cstrip_pkg::*;

    // Control and scalar lexer state
    t_state              r_state, n_state;
    t_lex_mode           r_mode, n_mode;
    logic [CNT_W-1:0]    r_raw, n_raw;
    logic [CNT_W-1:0]    r_kept, n_kept;
    logic                r_has, n_has;
    logic                r_prev_blank, n_prev_blank;
    logic [CHAR_W-1:0]   r_pend0, n_pend0;
    logic [CHAR_W-1:0]   r_pend1, n_pend1;
    logic [1:0]          r_pcnt, n_pcnt;
    logic                r_end, n_end;
    logic                r_emit, n_emit;
    logic [CNT_W-1:0]    r_len, n_len;
    logic [CNT_W-1:0]    r_rd, n_rd;
    logic                r_ramv, n_ramv;
    logic                r_ram_last, n_ram_last;
    logic                r_ovalid;
    logic [CHAR_W-1:0]   r_odata;
    logic                r_olast;

    // Step decode
    logic                in_accept;
    logic                proc;
    t_lex_res            lx;
    t_lex_mode           mode_a;
    logic [CNT_W-1:0]    raw_a;
    logic                end_line;
    logic                pend_kept;
    logic [CHAR_W-1:0]   pend_byte;
    logic [1:0]          kc;
    logic [1:0]          s_cnt;
    logic [CHAR_W-1:0]   s_b0;
    logic [CHAR_W-1:0]   s_b1;
    logic                content;
    logic                blank;

    // Store access
    logic                wr_en;
    logic [CNT_W-1:0]    kept_fin;
    logic                rd_issue;
    logic                issue_last;
    logic                out_load;
    logic [CHAR_W-1:0]   ram_rdata;
    logic [CNT_W-1:0]    rd_next;

    assign in_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // Run one byte through the lexer and the line-end rules
    always_comb begin
        proc   = !(i_in.end_of_input && (i_in.char_in == CH_NUL));
        lx     = lex_step(r_mode, i_in.char_in);
        mode_a = proc ? lx.mode : r_mode;
        raw_a  = r_raw + (proc ? CNT_W'(1) : CNT_W'(0));
        end_line = (proc && ((i_in.char_in == CH_NL) || (raw_a >= CNT_W'(LINE_LEN))))
                   || (i_in.end_of_input && (raw_a != '0));
        pend_kept = end_line && ((mode_a == LM_SLASH) || (mode_a == LM_STAR));
        pend_byte = (mode_a == LM_SLASH) ? CH_SLASH : CH_STAR;
        kc    = proc ? lx.cnt : 2'd0;
        s_b0  = lx.b0;
        s_b1  = lx.b1;
        s_cnt = kc;
        if (pend_kept) begin
            if (kc == 2'd0) begin
                s_b0 = pend_byte;
            end else begin
                s_b1 = pend_byte;
            end
            s_cnt = kc + 2'd1;
        end
        content = r_has
                  || ((s_cnt != 2'd0) && is_content(s_b0))
                  || ((s_cnt == 2'd2) && is_content(s_b1));
        blank = !content;
    end

    // Write the queued kept bytes into the line store
    assign wr_en    = (r_state == ST_WRITE) && (r_pcnt != 2'd0)
                      && (r_kept < CNT_W'(STORE_DEPTH));
    assign kept_fin = r_kept + (wr_en ? CNT_W'(1) : CNT_W'(0));

    // Stream the line out of the store
    assign out_load   = r_ramv && (!r_ovalid || o_out.ready);
    assign rd_issue   = (r_state == ST_EMIT) && (!r_ramv || out_load);
    assign rd_next    = r_rd + CNT_W'(1);
    assign issue_last = (rd_next == r_len);

    cstrip_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_kept[ADDR_W-1:0]),
        .i_wdata (r_pend0),
        .i_re    (rd_issue),
        .i_raddr (r_rd[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Next state and state updates
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_raw        = r_raw;
        n_kept       = r_kept;
        n_has        = r_has;
        n_prev_blank = r_prev_blank;
        n_pend0      = r_pend0;
        n_pend1      = r_pend1;
        n_pcnt       = r_pcnt;
        n_end        = r_end;
        n_emit       = r_emit;
        n_len        = r_len;
        n_rd         = r_rd;
        n_ramv       = r_ramv;
        n_ram_last   = r_ram_last;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_in.end_of_input || pend_kept) begin
                        n_mode = LM_CODE;
                    end else begin
                        n_mode = mode_a;
                    end
                    n_raw   = end_line ? '0 : raw_a;
                    n_has   = end_line ? 1'b0 : content;
                    if (i_in.end_of_input) begin
                        n_prev_blank = 1'b1;
                    end else if (end_line) begin
                        n_prev_blank = blank;
                    end
                    n_pend0 = s_b0;
                    n_pend1 = s_b1;
                    n_pcnt  = s_cnt;
                    n_end   = end_line;
                    n_emit  = end_line && !(r_prev_blank && blank);
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (r_pcnt > 2'd1) begin
                    // advance to the second queued byte
                    n_pend0 = r_pend1;
                    n_pcnt  = r_pcnt - 2'd1;
                    n_kept  = kept_fin;
                end else begin
                    n_pcnt = 2'd0;
                    if (!r_end) begin
                        n_kept  = kept_fin;
                        n_state = ST_IDLE;
                    end else begin
                        n_kept = '0;
                        if (r_emit && (kept_fin != '0)) begin
                            n_len   = kept_fin;
                            n_rd    = '0;
                            n_state = ST_EMIT;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (rd_issue) begin
                    n_rd = rd_next;
                    if (issue_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Track the byte sitting in the store's read register
        if (rd_issue) begin
            n_ramv     = 1'b1;
            n_ram_last = issue_last;
        end else if (out_load) begin
            n_ramv = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mode       <= LM_CODE;
            r_raw        <= '0;
            r_kept       <= '0;
            r_has        <= 1'b0;
            r_prev_blank <= 1'b1;
            r_pcnt       <= 2'd0;
            r_end        <= 1'b0;
            r_emit       <= 1'b0;
            r_ramv       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_raw        <= n_raw;
            r_kept       <= n_kept;
            r_has        <= n_has;
            r_prev_blank <= n_prev_blank;
            r_pcnt       <= n_pcnt;
            r_end        <= n_end;
            r_emit       <= n_emit;
            r_ramv       <= n_ramv;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend0    <= n_pend0;
        r_pend1    <= n_pend1;
        r_len      <= n_len;
        r_rd       <= n_rd;
        r_ram_last <= n_ram_last;
    end

    // Output register: load from the store, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_odata <= ram_rdata;
            r_olast <= r_ram_last;
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.char_out = r_odata;
    assign o_out.last     = r_olast;

endmodule

`default_nettype wire

// ===== rtl/cstrip_checker.sv =====
`default_nettype none

module cstrip_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_char,
    input wire logic       i_out_last
);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_char) && $stable(i_out_last))
        else $error("output payload changed while stalled");

    // Each accepted byte occupies the store write path for the next cycle
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken in the cycle after a beat");

    // Reset leaves no beat on the output
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind c_comment_stripper cstrip_checker u_cstrip_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.char_out),
    .i_out_last  (o_out.last)
);

`default_nettype wire

// ===== sim/c_comment_stripper_tb.sv =====
`timescale 1ns / 100ps

module c_comment_stripper_tb;
    import cstrip_pkg::*;

    localparam int unsigned CLK_HALF     = 4;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned RANDOM_BYTES = 24;
    localparam int unsigned IDLE_PCT     = 27;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam longint unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_line_beat;

    logic i_clk;
    logic i_rst_n;

    cstrip_in_if  in_if ();
    cstrip_out_if out_if ();

    c_comment_stripper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Stripper state as seen from outside
    t_lex_mode         lex_mode;
    logic [CHAR_W-1:0] line_buf [STORE_DEPTH];
    int unsigned       kept_n;
    int unsigned       raw_n;
    bit                line_has_text;
    bit                prior_blank;
    t_line_beat        line_beats_q [$];

    int unsigned     fail_count;
    int unsigned     bytes_sent;
    int unsigned     flushes_sent;
    int unsigned     beats_seen;
    int unsigned     lines_seen;
    bit              send_idle_on = 1'b1;
    bit              recv_idle_on = 1'b1;
    int unsigned     recv_hold_req;
    int unsigned     recv_hold_left;
    longint unsigned cycle_count;

    string stray_pieces [8] = '{"*/", "**/", "/x", "*q", "/\n", "*\n", "**\n", "/ "};

    // ------------------------------------------------------------------
    // Line predictor
    // ------------------------------------------------------------------
    function automatic void reset_model();
        lex_mode      = LM_CODE;
        kept_n        = 0;
        raw_n         = 0;
        line_has_text = 1'b0;
        prior_blank   = 1'b1;
    endfunction

    function automatic bit is_text_char(logic [CHAR_W-1:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               c == CH_LBRACE || c == CH_RBRACE;
    endfunction

    function automatic void keep_byte(logic [CHAR_W-1:0] c);
        if (kept_n < STORE_DEPTH) begin
            line_buf[kept_n] = c;
            kept_n++;
        end
        if (is_text_char(c)) begin
            line_has_text = 1'b1;
        end
    endfunction

    // Slash and star are held back until the next byte decides
    function automatic void code_byte(logic [CHAR_W-1:0] c);
        if (c == CH_SLASH) begin
            lex_mode = LM_SLASH;
        end else if (c == CH_STAR) begin
            lex_mode = LM_STAR;
        end else begin
            lex_mode = LM_CODE;
            keep_byte(c);
        end
    endfunction

    function automatic void lex_byte(logic [CHAR_W-1:0] c);
        case (lex_mode)
            LM_SLASH: begin
                if (c == CH_STAR) begin
                    lex_mode = LM_BLOCK;
                end else if (c == CH_SLASH) begin
                    lex_mode = LM_LINE;
                end else begin
                    keep_byte(CH_SLASH);
                    code_byte(c);
                end
            end
            LM_STAR: begin
                if (c == CH_SLASH) begin
                    lex_mode = LM_CODE;
                end else if (c == CH_STAR) begin
                    keep_byte(CH_STAR);
                end else begin
                    keep_byte(CH_STAR);
                    code_byte(c);
                end
            end
            LM_BLOCK: begin
                if (c == CH_STAR) begin
                    lex_mode = LM_BSTAR;
                end else if (c == CH_NL) begin
                    keep_byte(c);
                end
            end
            LM_BSTAR: begin
                if (c == CH_SLASH) begin
                    lex_mode = LM_CODE;
                end else if (c != CH_STAR) begin
                    lex_mode = LM_BLOCK;
                    if (c == CH_NL) begin
                        keep_byte(c);
                    end
                end
            end
            LM_LINE: begin
                if (c == CH_NL) begin
                    keep_byte(c);
                    lex_mode = LM_CODE;
                end
            end
            default: begin
                code_byte(c);
            end
        endcase
    endfunction

    // Finish the line: flush a held slash or star, then queue its bytes
    function automatic void close_line();
        bit          blank;
        int unsigned i;
        if (lex_mode == LM_SLASH) begin
            keep_byte(CH_SLASH);
            lex_mode = LM_CODE;
        end else if (lex_mode == LM_STAR) begin
            keep_byte(CH_STAR);
            lex_mode = LM_CODE;
        end
        blank = !line_has_text;
        if (!(prior_blank && blank)) begin
            for (i = 0; i < kept_n; i++) begin
                line_beats_q.push_back('{ch: line_buf[i], last: (i + 1 == kept_n)});
            end
        end
        prior_blank   = blank;
        kept_n        = 0;
        raw_n         = 0;
        line_has_text = 1'b0;
    endfunction

    function automatic void predict_beat(logic [CHAR_W-1:0] c, logic eoi);
        if (!(eoi && c == CH_NUL)) begin
            lex_byte(c);
            raw_n++;
            if (c == CH_NL || raw_n >= LINE_LEN) begin
                close_line();
            end
        end
        if (eoi) begin
            if (raw_n > 0) begin
                close_line();
            end
            lex_mode    = LM_CODE;
            prior_blank = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, receiver and checking
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Drive ready: random idling, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (recv_hold_req != 0) begin
            recv_hold_left = recv_hold_req;
            recv_hold_req  = 0;
        end
        if (recv_hold_left != 0) begin
            recv_hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= !(recv_idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Compare each output beat with the oldest expected line byte
    always @(posedge i_clk) begin
        t_line_beat want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            beats_seen++;
            if (line_beats_q.size() == 0) begin
                $error("unexpected beat: char_out=%h last=%b", out_if.char_out, out_if.last);
                fail_count++;
            end else begin
                want = line_beats_q.pop_front();
                if (out_if.char_out !== want.ch) begin
                    $error("char_out mismatch: expected %h, actual %h",
                           want.ch, out_if.char_out);
                    fail_count++;
                end
                if (out_if.last !== want.last) begin
                    $error("last mismatch: expected %b, actual %b", want.last, out_if.last);
                    fail_count++;
                end
                if (want.last) begin
                    lines_seen++;
                end
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [CHAR_W-1:0] c, input logic eoi);
        int unsigned gap;
        gap = 0;
        while (send_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            gap++;
        end
        @(negedge i_clk);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.char_in      <= c;
        in_if.end_of_input <= eoi;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predict_beat(c, eoi);
        bytes_sent++;
        if (eoi) begin
            flushes_sent++;
        end
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_byte(s[i], 1'b0);
        end
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (line_beats_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CHAR_W-1:0] rand_letter();
        int unsigned pick;
        pick = $urandom_range(0, 51);
        return (pick < 26) ? CHAR_W'("a" + pick) : CHAR_W'("A" + pick - 26);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_from(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // One piece of C-like text; mostly well-formed, some noise
    task automatic send_fragment();
        int unsigned kind;
        int unsigned n;
        int unsigned i;
        kind = $urandom_range(0, 99);
        if (kind < 22) begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) send_byte(rand_letter(), 1'b0);
        end else if (kind < 34) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) send_byte(rand_from(" \t;(),=+-0123456789<>#"), 1'b0);
        end else if (kind < 46) begin
            send_byte(CH_NL, 1'b0);
        end else if (kind < 57) begin
            send_text("/*");
            n = $urandom_range(0, 12);
            for (i = 0; i < n; i++) send_byte(rand_from("ab *\n/x*"), 1'b0);
            if ($urandom_range(0, 9) != 0) send_text("*/");
        end else if (kind < 66) begin
            send_text("//");
            n = $urandom_range(0, 10);
            for (i = 0; i < n; i++) send_byte(rand_from("ab */{ \t"), 1'b0);
            send_byte(CH_NL, 1'b0);
        end else if (kind < 71) begin
            send_byte(rand_from("{}"), 1'b0);
            if ($urandom_range(0, 1) != 0) send_byte(CH_NL, 1'b0);
        end else if (kind < 76) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 1) != 0) send_text("  ");
                send_byte(CH_NL, 1'b0);
            end
        end else if (kind < 82) begin
            send_text(stray_pieces[$urandom_range(0, 7)]);
        end else if (kind < 92) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) send_byte(CHAR_W'($urandom_range(0, 255)), 1'b0);
        end else if (kind < 97) begin
            if ($urandom_range(0, 1) != 0) begin
                send_byte(CH_NUL, 1'b1);
            end else begin
                send_byte(CHAR_W'($urandom_range(0, 255)), 1'b1);
            end
        end else begin
            // Long run that may cross a segment break, sometimes inside a comment
            n = $urandom_range(60, 90);
            if ($urandom_range(0, 1) != 0) send_text("/*");
            for (i = 0; i < n; i++) send_byte(rand_from("abc xyz "), 1'b0);
            send_text("*/\n");
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_flush_alone();
        send_byte(CH_NUL, 1'b1);
    endtask

    task automatic test_block_comment();
        send_text("a/*x\n*/b\n");
    endtask

    task automatic test_line_comment();
        send_text("{//q\n");
    endtask

    task automatic test_stray_close();
        send_text("*/**\n");
    endtask

    task automatic test_byte_extremes();
        send_text("Z");
        send_byte(8'hFF, 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte(CH_NL, 1'b0);
    endtask

    task automatic test_pending_slash_at_end();
        send_byte(CH_SLASH, 1'b1);
    endtask

    // Hold the sender until every line so far has left the block
    task automatic test_pause_until_drained();
        drop_valid();
        wait_drained();
    endtask

    task automatic test_segment_edges();
        int unsigned i;
        // Held slash as the last raw byte of a segment
        for (i = 0; i + 1 < LINE_LEN; i++) send_byte(rand_letter(), 1'b0);
        send_byte(CH_SLASH, 1'b0);
        send_text("x\n");
        // Block comment opens on the segment break and runs into the next line
        for (i = 0; i + 2 < LINE_LEN; i++) send_byte(rand_from("q {"), 1'b0);
        send_text("/*");
        send_text("ab*/b\n");
        // Line comment opens on the segment break and runs on to the newline
        for (i = 0; i + 2 < LINE_LEN; i++) send_byte(rand_letter(), 1'b0);
        send_text("//");
        send_text("a{\n");
        // Held star closes the input, then a flush with nothing pending
        send_byte(CH_STAR, 1'b1);
        send_byte(CH_NUL, 1'b1);
    endtask

    task automatic test_no_idle_stretch();
        int unsigned i;
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        for (i = 0; i < 6; i++) send_fragment();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    // Receiver stalls while the sender keeps offering lines
    task automatic test_output_backpressure();
        int unsigned i;
        recv_hold_req = HOLD_CYCLES;
        for (i = 0; i < 3; i++) begin
            send_text("int ");
            send_byte(rand_letter(), 1'b0);
            send_text(" = {1}; /* c */\n");
        end
    endtask

    task automatic test_random_text();
        int unsigned target;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) send_fragment();
        send_byte(CH_NUL, 1'b1);
    endtask

    initial begin
        in_if.valid        = 1'b0;
        in_if.char_in      = '0;
        in_if.end_of_input = 1'b0;
        out_if.ready       = 1'b0;
        i_rst_n            = 1'b0;
        reset_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_flush_alone();
        test_block_comment();
        test_line_comment();
        test_stray_close();
        test_byte_extremes();
        test_pending_slash_at_end();
        test_pause_until_drained();
        test_segment_edges();
        test_output_backpressure();
        test_no_idle_stretch();
        test_pause_until_drained();
        test_random_text();

        drop_valid();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d source bytes (%0d with end of input), checked %0d beats in %0d lines.",
                 bytes_sent, flushes_sent, beats_seen, lines_seen);
        $display("Covered block, line and stray comments, segment breaks, blank-line collapse, stalls.");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
